// File: rtl/core/rsitts_pkg.sv
// ----------------------------------------------------------------------------
// rsitts_pkg
// Shared types and constants for the RSI threshold trade signal block.
// ----------------------------------------------------------------------------
package rsitts_pkg;

   // CSR port geometry
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register indexes (byte address = 4 * index)
   typedef enum logic [1:0] {
      REG_WINDOW_LEN     = 2'd0,
      REG_POSITION_LIMIT = 2'd1,
      REG_OVERSOLD       = 2'd2,
      REG_OVERBOUGHT     = 2'd3
   } reg_index_type;

   // Field widths
   localparam int WLEN_W      = 7;
   localparam int LIMIT_W     = 10;
   localparam int LEVEL_W     = 7;
   localparam int HOLD_W      = 11;
   localparam int CASH_W      = 48;
   localparam int PNL_W       = 49;
   localparam int CASH_CALC_W = 50;
   localparam int RSP_TDATA_W = 112;

   // Field positions inside rsp_tdata
   localparam int HOLD_LSB = 0;
   localparam int CASH_LSB = HOLD_LSB + HOLD_W;
   localparam int PNL_LSB  = CASH_LSB + CASH_W;

   // Register reset values
   localparam logic [WLEN_W-1:0]  WINDOW_LEN_RST     = 7'd14;
   localparam logic [LIMIT_W-1:0] POSITION_LIMIT_RST = 10'd5;
   localparam logic [LEVEL_W-1:0] OVERSOLD_RST       = 7'd30;
   localparam logic [LEVEL_W-1:0] OVERBOUGHT_RST     = 7'd70;

   // RSI full scale
   localparam logic [LEVEL_W-1:0] RSI_SCALE = 7'd100;

   typedef enum logic [1:0] {
      ACT_NONE = 2'd0,
      ACT_BUY  = 2'd1,
      ACT_SELL = 2'd2
   } action_type;

   typedef struct packed {
      logic [WLEN_W-1:0]  window_len;
      logic [LIMIT_W-1:0] position_limit;
      logic [LEVEL_W-1:0] oversold_level;
      logic [LEVEL_W-1:0] overbought_level;
   } cfg_type;

   typedef struct packed {
      logic trading_phase;
      logic end_of_series;
   } flags_type;

endpackage

// File: rtl/core/rsitts_csr.sv
// ----------------------------------------------------------------------------
// rsitts_csr
// APB-style register file holding the window and trading thresholds.
// ----------------------------------------------------------------------------
module rsitts_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rsitts_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [rsitts_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [rsitts_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                csr_pready,
   output rsitts_pkg::cfg_type                 cfg
);

   rsitts_pkg::cfg_type       cfg_ff;
   rsitts_pkg::cfg_type       cfg_in;
   rsitts_pkg::reg_index_type reg_idx;
   logic                      wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = rsitts_pkg::reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            rsitts_pkg::REG_WINDOW_LEN: begin
               cfg_in.window_len = csr_pwdata[rsitts_pkg::WLEN_W-1:0];
            end
            rsitts_pkg::REG_POSITION_LIMIT: begin
               cfg_in.position_limit = csr_pwdata[rsitts_pkg::LIMIT_W-1:0];
            end
            rsitts_pkg::REG_OVERSOLD: begin
               cfg_in.oversold_level = csr_pwdata[rsitts_pkg::LEVEL_W-1:0];
            end
            rsitts_pkg::REG_OVERBOUGHT: begin
               cfg_in.overbought_level = csr_pwdata[rsitts_pkg::LEVEL_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_len       <= rsitts_pkg::WINDOW_LEN_RST;
         cfg_ff.position_limit   <= rsitts_pkg::POSITION_LIMIT_RST;
         cfg_ff.oversold_level   <= rsitts_pkg::OVERSOLD_RST;
         cfg_ff.overbought_level <= rsitts_pkg::OVERBOUGHT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      csr_prdata = '0;
      case (reg_idx)
         rsitts_pkg::REG_WINDOW_LEN: begin
            csr_prdata = rsitts_pkg::CSR_DATA_W'(cfg_ff.window_len);
         end
         rsitts_pkg::REG_POSITION_LIMIT: begin
            csr_prdata = rsitts_pkg::CSR_DATA_W'(cfg_ff.position_limit);
         end
         rsitts_pkg::REG_OVERSOLD: begin
            csr_prdata = rsitts_pkg::CSR_DATA_W'(cfg_ff.oversold_level);
         end
         rsitts_pkg::REG_OVERBOUGHT: begin
            csr_prdata = rsitts_pkg::CSR_DATA_W'(cfg_ff.overbought_level);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

endmodule

// File: rtl/core/rsitts_window.sv
// ----------------------------------------------------------------------------
// rsitts_window
// Price change tracking and windowed gain/loss sums. Running cumulative
// gain and loss totals are kept in registers; a ring memory stores the
// totals seen before each change, so a window sum is one subtraction.
// ----------------------------------------------------------------------------
module rsitts_window #(
   parameter int MAX_WINDOW = 64,
   parameter int PRICE_BITS = 32,
   parameter int SUM_W      = 38
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [PRICE_BITS-1:0]             in_price,
   input  rsitts_pkg::flags_type             in_flags,
   input  logic [rsitts_pkg::WLEN_W-1:0]     window_len,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [PRICE_BITS-1:0]             out_price,
   output rsitts_pkg::flags_type             out_flags,
   output logic [SUM_W-1:0]                  out_gain,
   output logic [SUM_W-1:0]                  out_loss
);

   localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CNT_W = $clog2(MAX_WINDOW + 1);
   localparam int LEN_W = (CNT_W > rsitts_pkg::WLEN_W) ? CNT_W : rsitts_pkg::WLEN_W;
   localparam int ADR_W = CNT_W + 1;

   // accept-side state
   logic [PRICE_BITS-1:0] prev_price_ff, prev_price_in;
   logic                  have_prev_ff, have_prev_in;
   logic [PTR_W-1:0]      ptr_ff, ptr_in;
   logic [CNT_W-1:0]      seen_ff, seen_in;
   logic [SUM_W-1:0]      cum_gain_ff, cum_gain_in;
   logic [SUM_W-1:0]      cum_loss_ff, cum_loss_in;

   // totals before each change, one entry per ring slot
   logic [2*SUM_W-1:0]    base_mem [MAX_WINDOW];
   logic [2*SUM_W-1:0]    mem_q_ff;

   // stage 1: accepted request plus memory read
   logic                  st1_valid_ff;
   logic [PRICE_BITS-1:0] st1_price_ff;
   rsitts_pkg::flags_type st1_flags_ff;
   logic [SUM_W-1:0]      st1_gain_ff;
   logic [SUM_W-1:0]      st1_loss_ff;
   logic                  st1_empty_ff;
   logic                  st1_byp_ff;
   logic [2*SUM_W-1:0]    st1_wdat_ff;

   // stage 2: window sums
   logic                  st2_valid_ff;
   logic [PRICE_BITS-1:0] st2_price_ff;
   rsitts_pkg::flags_type st2_flags_ff;
   logic [SUM_W-1:0]      st2_gain_ff, st2_gain_in;
   logic [SUM_W-1:0]      st2_loss_ff, st2_loss_in;

   logic                  accept;
   logic                  st1_load;
   logic                  st2_load;
   logic [PRICE_BITS:0]   diff;
   logic [PRICE_BITS-1:0] up_mag;
   logic [PRICE_BITS-1:0] down_mag;
   logic [PTR_W-1:0]      ptr_next;
   logic [CNT_W-1:0]      seen_next;
   logic [PTR_W-1:0]      ptr_new;
   logic [CNT_W-1:0]      seen_new;
   logic [LEN_W-1:0]      wlen_ext;
   logic [LEN_W-1:0]      w_eff;
   logic [CNT_W-1:0]      n_win;
   logic [ADR_W-1:0]      rd_a;
   logic [ADR_W-1:0]      rd_b;
   logic [ADR_W-1:0]      rd_full;
   logic [PTR_W-1:0]      rd_addr;
   logic                  bypass;
   logic [2*SUM_W-1:0]    base_sel;

   // handshake chain
   assign st2_load = !st2_valid_ff || out_ready;
   assign st1_load = !st1_valid_ff || st2_load;
   assign in_ready = st1_load;
   assign accept   = in_valid && in_ready;

   // price change split into gain and loss magnitudes
   assign diff     = {1'b0, in_price} - {1'b0, prev_price_ff};
   assign up_mag   = diff[PRICE_BITS] ? '0 : diff[PRICE_BITS-1:0];
   assign down_mag = diff[PRICE_BITS] ? (prev_price_ff - in_price) : '0;

   // ring pointer and fill count after this request
   assign ptr_next  = (ptr_ff == PTR_W'(MAX_WINDOW - 1)) ? '0 : ptr_ff + 1'b1;
   assign seen_next = (seen_ff == CNT_W'(MAX_WINDOW)) ? seen_ff : seen_ff + 1'b1;
   assign ptr_new   = have_prev_ff ? ptr_next : ptr_ff;
   assign seen_new  = have_prev_ff ? seen_next : seen_ff;

   // effective window: zero acts as one, clamp at the ring depth
   assign wlen_ext = LEN_W'(window_len);
   always_comb begin
      if (wlen_ext == '0) begin
         w_eff = LEN_W'(1);
      end else if (wlen_ext > LEN_W'(MAX_WINDOW)) begin
         w_eff = LEN_W'(MAX_WINDOW);
      end else begin
         w_eff = wlen_ext;
      end
   end
   assign n_win = (LEN_W'(seen_new) < w_eff) ? seen_new : CNT_W'(w_eff);

   // slot of the oldest change in the window
   assign rd_a    = ADR_W'(ptr_new);
   assign rd_b    = ADR_W'(n_win);
   assign rd_full = (rd_a >= rd_b) ? (rd_a - rd_b) : (rd_a + ADR_W'(MAX_WINDOW) - rd_b);
   assign rd_addr = rd_full[PTR_W-1:0];
   assign bypass  = have_prev_ff && (rd_addr == ptr_ff);

   // accept-side state update
   always_comb begin
      prev_price_in = prev_price_ff;
      have_prev_in  = have_prev_ff;
      ptr_in        = ptr_ff;
      seen_in       = seen_ff;
      cum_gain_in   = cum_gain_ff;
      cum_loss_in   = cum_loss_ff;
      if (accept) begin
         prev_price_in = in_price;
         have_prev_in  = 1'b1;
         ptr_in        = ptr_new;
         seen_in       = seen_new;
         if (have_prev_ff) begin
            cum_gain_in = cum_gain_ff + SUM_W'(up_mag);
            cum_loss_in = cum_loss_ff + SUM_W'(down_mag);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_price_ff <= '0;
         have_prev_ff  <= 1'b0;
         ptr_ff        <= '0;
         seen_ff       <= '0;
         cum_gain_ff   <= '0;
         cum_loss_ff   <= '0;
      end else begin
         prev_price_ff <= prev_price_in;
         have_prev_ff  <= have_prev_in;
         ptr_ff        <= ptr_in;
         seen_ff       <= seen_in;
         cum_gain_ff   <= cum_gain_in;
         cum_loss_ff   <= cum_loss_in;
      end
   end

   // ring memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (accept && have_prev_ff) begin
         base_mem[ptr_ff] <= {cum_gain_ff, cum_loss_ff};
      end
      if (accept) begin
         mem_q_ff <= base_mem[rd_addr];
      end
   end

   // stage 1 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st1_valid_ff <= 1'b0;
      end else if (st1_load) begin
         st1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         st1_price_ff <= in_price;
         st1_flags_ff <= in_flags;
         st1_gain_ff  <= cum_gain_in;
         st1_loss_ff  <= cum_loss_in;
         st1_empty_ff <= (n_win == '0);
         st1_byp_ff   <= bypass;
         st1_wdat_ff  <= {cum_gain_ff, cum_loss_ff};
      end
   end

   // stage 2: window sum = total now minus total before oldest change
   assign base_sel = st1_byp_ff ? st1_wdat_ff : mem_q_ff;

   always_comb begin
      if (st1_empty_ff) begin
         st2_gain_in = '0;
         st2_loss_in = '0;
      end else begin
         st2_gain_in = st1_gain_ff - base_sel[2*SUM_W-1:SUM_W];
         st2_loss_in = st1_loss_ff - base_sel[SUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st2_valid_ff <= 1'b0;
      end else if (st2_load) begin
         st2_valid_ff <= st1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (st2_load && st1_valid_ff) begin
         st2_price_ff <= st1_price_ff;
         st2_flags_ff <= st1_flags_ff;
         st2_gain_ff  <= st2_gain_in;
         st2_loss_ff  <= st2_loss_in;
      end
   end

   assign out_valid = st2_valid_ff;
   assign out_price = st2_price_ff;
   assign out_flags = st2_flags_ff;
   assign out_gain  = st2_gain_ff;
   assign out_loss  = st2_loss_ff;

endmodule

// File: rtl/core/rsitts_trade.sv
// ----------------------------------------------------------------------------
// rsitts_trade
// RSI threshold tests, position and cash bookkeeping, and end-of-series PnL.
// ----------------------------------------------------------------------------
module rsitts_trade #(
   parameter int PRICE_BITS = 32,
   parameter int SUM_W      = 38
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  rsitts_pkg::cfg_type                    cfg,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic [PRICE_BITS-1:0]                  in_price,
   input  rsitts_pkg::flags_type                  in_flags,
   input  logic [SUM_W-1:0]                       in_gain,
   input  logic [SUM_W-1:0]                       in_loss,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output rsitts_pkg::action_type                 rsp_action,
   output logic signed [rsitts_pkg::HOLD_W-1:0]   rsp_holding,
   output logic signed [rsitts_pkg::CASH_W-1:0]   rsp_cash,
   output logic signed [rsitts_pkg::PNL_W-1:0]    rsp_pnl,
   output logic                                   rsp_pnl_valid
);

   localparam int HOLD_W  = rsitts_pkg::HOLD_W;
   localparam int CASH_W  = rsitts_pkg::CASH_W;
   localparam int PNL_W   = rsitts_pkg::PNL_W;
   localparam int CALC_W  = rsitts_pkg::CASH_CALC_W;
   localparam int TOT_W   = SUM_W + 1;
   localparam int PROD_W  = TOT_W + rsitts_pkg::LEVEL_W;
   localparam int PPROD_W = HOLD_W + PRICE_BITS + 1;
   localparam int PSUM_W  = ((PPROD_W > PNL_W) ? PPROD_W : PNL_W) + 1;

   localparam logic signed [CASH_W-1:0] CASH_MAX = {1'b0, {(CASH_W-1){1'b1}}};
   localparam logic signed [CASH_W-1:0] CASH_MIN = {1'b1, {(CASH_W-1){1'b0}}};
   localparam logic signed [PNL_W-1:0]  PNL_MAX  = {1'b0, {(PNL_W-1){1'b1}}};
   localparam logic signed [PNL_W-1:0]  PNL_MIN  = {1'b1, {(PNL_W-1){1'b0}}};

   // handshake chain
   logic st3_load, st4_load, st5_load, out_load;

   // stage 3: RSI tests
   logic                  st3_valid_ff;
   logic [PRICE_BITS-1:0] st3_price_ff;
   rsitts_pkg::flags_type st3_flags_ff;
   logic                  st3_buy_rsi_ff, st3_buy_rsi_in;
   logic                  st3_sell_rsi_ff, st3_sell_rsi_in;
   logic [TOT_W-1:0]      total;
   logic [PROD_W-1:0]     scaled_gain;
   logic [PROD_W-1:0]     os_prod;
   logic [PROD_W-1:0]     ob_prod;

   // stage 4: trade decision and state
   logic                          st4_valid_ff;
   logic [PRICE_BITS-1:0]         st4_price_ff;
   logic                          st4_end_ff;
   rsitts_pkg::action_type        st4_action_ff, st4_action_in;
   logic signed [HOLD_W-1:0]      st4_hold_ff, st4_hold_in;
   logic signed [CASH_W-1:0]      st4_cash_ff, st4_cash_in;
   logic signed [HOLD_W-1:0]      units_ff, units_in;
   logic signed [CASH_W-1:0]      cash_ff;
   logic signed [HOLD_W-1:0]      lim_s;
   logic                          buy;
   logic                          sell;
   logic signed [CALC_W-1:0]      cash_ext;
   logic signed [CALC_W-1:0]      price_ext;
   logic signed [CALC_W-1:0]      cash_sum;

   // stage 5: holding times price
   logic                          st5_valid_ff;
   logic                          st5_end_ff;
   rsitts_pkg::action_type        st5_action_ff;
   logic signed [HOLD_W-1:0]      st5_hold_ff;
   logic signed [CASH_W-1:0]      st5_cash_ff;
   logic signed [PPROD_W-1:0]     st5_prod_ff, st5_prod_in;

   // output register
   logic                          out_valid_ff;
   rsitts_pkg::action_type        out_action_ff;
   logic signed [HOLD_W-1:0]      out_hold_ff;
   logic signed [CASH_W-1:0]      out_cash_ff;
   logic signed [PNL_W-1:0]       out_pnl_ff, out_pnl_in;
   logic                          out_end_ff;
   logic signed [PSUM_W-1:0]      pnl_sum;

   assign out_load = !out_valid_ff || rsp_ready;
   assign st5_load = !st5_valid_ff || out_load;
   assign st4_load = !st4_valid_ff || st5_load;
   assign st3_load = !st3_valid_ff || st4_load;
   assign in_ready = st3_load;

   // 100*G against level*(G+L); an empty window never trades
   assign total       = TOT_W'(in_gain) + TOT_W'(in_loss);
   assign scaled_gain = PROD_W'(in_gain) * PROD_W'(rsitts_pkg::RSI_SCALE);
   assign os_prod     = PROD_W'(total) * PROD_W'(cfg.oversold_level);
   assign ob_prod     = PROD_W'(total) * PROD_W'(cfg.overbought_level);
   assign st3_buy_rsi_in  = (total != '0) && (scaled_gain < os_prod);
   assign st3_sell_rsi_in = (total != '0) && (scaled_gain > ob_prod);

   always_ff @(posedge clock) begin
      if (reset) begin
         st3_valid_ff <= 1'b0;
      end else if (st3_load) begin
         st3_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (st3_load && in_valid) begin
         st3_price_ff    <= in_price;
         st3_flags_ff    <= in_flags;
         st3_buy_rsi_ff  <= st3_buy_rsi_in;
         st3_sell_rsi_ff <= st3_sell_rsi_in;
      end
   end

   // trade decision against position limits
   assign lim_s = $signed({1'b0, cfg.position_limit});
   assign buy   = st3_flags_ff.trading_phase && st3_buy_rsi_ff && (units_ff < lim_s);
   assign sell  = st3_flags_ff.trading_phase && !buy && st3_sell_rsi_ff
                  && (units_ff > -lim_s);

   // saturating cash update
   assign cash_ext  = CALC_W'(cash_ff);
   assign price_ext = $signed({{(CALC_W-PRICE_BITS){1'b0}}, st3_price_ff});
   assign cash_sum  = buy ? (cash_ext - price_ext) : (cash_ext + price_ext);

   always_comb begin
      st4_action_in = rsitts_pkg::ACT_NONE;
      st4_hold_in   = units_ff;
      st4_cash_in   = cash_ff;
      if (buy || sell) begin
         st4_action_in = buy ? rsitts_pkg::ACT_BUY : rsitts_pkg::ACT_SELL;
         st4_hold_in   = buy ? (units_ff + HOLD_W'(1)) : (units_ff - HOLD_W'(1));
         if ((cash_sum[CALC_W-1:CASH_W-1] == '0)
             || (cash_sum[CALC_W-1:CASH_W-1] == '1)) begin
            st4_cash_in = cash_sum[CASH_W-1:0];
         end else begin
            st4_cash_in = cash_sum[CALC_W-1] ? CASH_MIN : CASH_MAX;
         end
      end
      // square-off clears the position after the report
      units_in = st3_flags_ff.end_of_series ? '0 : st4_hold_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st4_valid_ff <= 1'b0;
         units_ff     <= '0;
         cash_ff      <= '0;
      end else begin
         if (st4_load) begin
            st4_valid_ff <= st3_valid_ff;
         end
         if (st4_load && st3_valid_ff) begin
            units_ff <= units_in;
            cash_ff  <= st4_cash_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (st4_load && st3_valid_ff) begin
         st4_price_ff  <= st3_price_ff;
         st4_end_ff    <= st3_flags_ff.end_of_series;
         st4_action_ff <= st4_action_in;
         st4_hold_ff   <= st4_hold_in;
         st4_cash_ff   <= st4_cash_in;
      end
   end

   // position value
   assign st5_prod_in = PPROD_W'(st4_hold_ff) * $signed({1'b0, st4_price_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         st5_valid_ff <= 1'b0;
      end else if (st5_load) begin
         st5_valid_ff <= st4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (st5_load && st4_valid_ff) begin
         st5_end_ff    <= st4_end_ff;
         st5_action_ff <= st4_action_ff;
         st5_hold_ff   <= st4_hold_ff;
         st5_cash_ff   <= st4_cash_ff;
         st5_prod_ff   <= st5_prod_in;
      end
   end

   // PnL with saturation, zero off the end item
   assign pnl_sum = PSUM_W'(st5_cash_ff) + PSUM_W'(st5_prod_ff);

   always_comb begin
      if (!st5_end_ff) begin
         out_pnl_in = '0;
      end else if ((pnl_sum[PSUM_W-1:PNL_W-1] == '0)
                   || (pnl_sum[PSUM_W-1:PNL_W-1] == '1)) begin
         out_pnl_in = pnl_sum[PNL_W-1:0];
      end else begin
         out_pnl_in = pnl_sum[PSUM_W-1] ? PNL_MIN : PNL_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= st5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && st5_valid_ff) begin
         out_action_ff <= st5_action_ff;
         out_hold_ff   <= st5_hold_ff;
         out_cash_ff   <= st5_cash_ff;
         out_pnl_ff    <= out_pnl_in;
         out_end_ff    <= st5_end_ff;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_action    = out_action_ff;
   assign rsp_holding   = out_hold_ff;
   assign rsp_cash      = out_cash_ff;
   assign rsp_pnl       = out_pnl_ff;
   assign rsp_pnl_valid = out_end_ff;

endmodule

// File: rtl/core/rsi_threshold_trade_signal_top.sv
// ----------------------------------------------------------------------------
// rsi_threshold_trade_signal_top
// RSI threshold trading on a price stream with APB-style configuration.
// ----------------------------------------------------------------------------
// Pipeline: six register stages (st1, st2, st3, st4, st5 and the output
//   register), the first loaded at the accepting edge.
// Throughput: one request per cycle unless the output stalls; six register
//   stages with per-stage valid bits, so bubbles close up behind a stalled output.
// Reset (synchronous, active high) clears the pipeline, position, cash and
//   registers; the change ring is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module rsi_threshold_trade_signal_top #(
   parameter int MAX_WINDOW = 64,
   parameter int PRICE_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((PRICE_BITS+7)/8)*8-1:0]      req_tdata,  // price, zero pad
   input  logic                                 req_tuser,  // trading_phase
   input  logic                                 req_tlast,  // end_of_series
   // response channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [rsitts_pkg::RSP_TDATA_W-1:0]   rsp_tdata,  // holding, cash_total,
                                                            // closing pnl, zero pad
   output logic [1:0]                           rsp_tuser,  // action
   output logic                                 rsp_tlast,  // pnl_valid
   // configuration
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [rsitts_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [rsitts_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [rsitts_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                 csr_pready
);

   localparam int SUM_W = PRICE_BITS + ((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1);
   localparam int PAD_W = rsitts_pkg::RSP_TDATA_W - rsitts_pkg::HOLD_W
                          - rsitts_pkg::CASH_W - rsitts_pkg::PNL_W;

   rsitts_pkg::cfg_type    cfg;
   rsitts_pkg::flags_type  req_flags;
   rsitts_pkg::flags_type  win_flags;
   logic                   win_valid;
   logic                   win_ready;
   logic [PRICE_BITS-1:0]  win_price;
   logic [SUM_W-1:0]       win_gain;
   logic [SUM_W-1:0]       win_loss;

   rsitts_pkg::action_type                     rsp_action;
   logic signed [rsitts_pkg::HOLD_W-1:0]       rsp_holding;
   logic signed [rsitts_pkg::CASH_W-1:0]       rsp_cash;
   logic signed [rsitts_pkg::PNL_W-1:0]        rsp_pnl;

   assign req_flags.trading_phase = req_tuser;
   assign req_flags.end_of_series = req_tlast;

   rsitts_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rsitts_window #(
      .MAX_WINDOW (MAX_WINDOW),
      .PRICE_BITS (PRICE_BITS),
      .SUM_W      (SUM_W)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_price   (req_tdata[PRICE_BITS-1:0]),
      .in_flags   (req_flags),
      .window_len (cfg.window_len),
      .out_valid  (win_valid),
      .out_ready  (win_ready),
      .out_price  (win_price),
      .out_flags  (win_flags),
      .out_gain   (win_gain),
      .out_loss   (win_loss)
   );

   rsitts_trade #(
      .PRICE_BITS (PRICE_BITS),
      .SUM_W      (SUM_W)
   ) u_trade (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .in_valid      (win_valid),
      .in_ready      (win_ready),
      .in_price      (win_price),
      .in_flags      (win_flags),
      .in_gain       (win_gain),
      .in_loss       (win_loss),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_action    (rsp_action),
      .rsp_holding   (rsp_holding),
      .rsp_cash      (rsp_cash),
      .rsp_pnl       (rsp_pnl),
      .rsp_pnl_valid (rsp_tlast)
   );

   // response packing, first field in the low bits
   assign rsp_tdata = {{PAD_W{1'b0}}, rsp_pnl, rsp_cash, rsp_holding};
   assign rsp_tuser = rsp_action;

endmodule

// File: rtl/core/rsitts_checker.sv
// ----------------------------------------------------------------------------
// rsitts_checker
// Port-level checks on the trade signal block, bound to the top level.
// ----------------------------------------------------------------------------
module rsitts_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [rsitts_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic [1:0]                          rsp_tuser,
   input logic                                rsp_tlast,
   input logic                                csr_pready
);

   localparam int PNL_LSB = rsitts_pkg::PNL_LSB;
   localparam int PNL_MSB = rsitts_pkg::PNL_LSB + rsitts_pkg::PNL_W - 1;

   // no response survives a reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // a stalled response holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // PnL field is only non-zero on the end-of-series response
   a_pnl_only_on_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> (rsp_tdata[PNL_MSB:PNL_LSB] == '0))
      else $error("closing pnl set on a non-end response");

   // configuration port never waits
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      !reset |-> csr_pready)
      else $error("csr_pready dropped");

endmodule

bind rsi_threshold_trade_signal_top rsitts_checker u_rsitts_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast),
   .csr_pready (csr_pready)
);

// File: test/rsi_threshold_trade_signal_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_threshold_trade_signal_top_tb
// Self-checking bench for the RSI threshold trade signal block. A price stream
// is driven into the request channel. A predictor in the bench keeps its own
// change ring, position and cash, and works out the response to each request.
// Every response is checked field by field against the oldest pending
// prediction. The run covers directed cases, random traffic under several
// idle and stall mixes, and output back-pressure.
// ----------------------------------------------------------------------------
module rsi_threshold_trade_signal_top_tb;

   localparam int     MAX_WIN = 64;
   localparam longint CASH_HI = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint CASH_LO = -CASH_HI - 1;
   localparam longint PNL_HI  = 64'sh0000_FFFF_FFFF_FFFF;
   localparam longint PNL_LO  = -PNL_HI - 1;

   typedef struct {
      rsitts_pkg::action_type act;
      logic [10:0]            hold;
      logic [47:0]            cash;
      logic [48:0]            pnl;
      logic                   pnl_flag;
   } trade_outcome_type;

   logic                              clock;
   logic                              reset;
   logic                              req_tvalid;
   logic                              req_tready;
   logic [31:0]                       req_tdata;   // price
   logic                              req_tuser;   // trading_phase
   logic                              req_tlast;   // end_of_series
   logic                              rsp_tvalid;
   logic                              rsp_tready;
   logic [rsitts_pkg::RSP_TDATA_W-1:0] rsp_tdata;  // holding, cash_total, closing pnl,
                                                   // zero pad
   logic [1:0]                        rsp_tuser;   // action
   logic                              rsp_tlast;   // pnl_valid
   logic                              csr_psel;
   logic                              csr_penable;
   logic                              csr_pwrite;
   logic [rsitts_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [rsitts_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [rsitts_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                              csr_pready;

   // predictor state
   rsitts_pkg::cfg_type cfg = '{rsitts_pkg::WINDOW_LEN_RST, rsitts_pkg::POSITION_LIMIT_RST,
                                rsitts_pkg::OVERSOLD_RST, rsitts_pkg::OVERBOUGHT_RST};
   longint      last_price = 0;
   bit          primed = 1'b0;
   longint      deltas [MAX_WIN];
   logic [5:0]  wr_ptr = '0;
   int unsigned deltas_seen = 0;
   int          units = 0;
   longint      cash_acc = 0;

   trade_outcome_type pending_outcomes [$];
   int                mismatch_count = 0;

   // traffic shaping
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          hold_left = 0;
   logic [31:0] walk_price = 32'd50_000_000;
   bit          trend_up = 1'b1;

   rsi_threshold_trade_signal_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Run limit, far above the slowest correct run
   initial begin
      #60_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Response side: random stalls, or a counted hold-off when asked
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Predict the response to one price request and advance the state
   function automatic trade_outcome_type predict_trade(input logic [31:0] price,
                                                       input logic trading,
                                                       input logic closing);
      trade_outcome_type r;
      longint            px;
      longint            lim;
      longint            pnl;
      longint unsigned   gains;
      longint unsigned   losses;
      longint unsigned   total;
      int unsigned       span;
      int unsigned       n;
      logic [5:0]        slot;
      px = price;
      if (primed) begin
         deltas[wr_ptr] = px - last_price;
         wr_ptr = wr_ptr + 1'b1;
         if (deltas_seen < MAX_WIN) deltas_seen++;
      end
      last_price = px;
      primed = 1'b1;

      // window clamp: zero acts as one, large values stop at the ring depth
      span = cfg.window_len;
      if (span == 0) span = 1;
      if (span > MAX_WIN) span = MAX_WIN;
      n = (deltas_seen < span) ? deltas_seen : span;
      gains = 0;
      losses = 0;
      for (int k = 0; k < n; k++) begin
         slot = 6'(wr_ptr - 1 - k);
         if (deltas[slot] > 0) gains += deltas[slot];
         else losses += -deltas[slot];
      end

      // RSI compare by cross-multiplication; flat window never trades
      r.act = rsitts_pkg::ACT_NONE;
      total = gains + losses;
      lim = cfg.position_limit;
      if (trading && total != 0) begin
         if (rsitts_pkg::RSI_SCALE * gains < cfg.oversold_level * total && units < lim) begin
            r.act = rsitts_pkg::ACT_BUY;
            units++;
            if (cash_acc - CASH_LO < px) cash_acc = CASH_LO;
            else cash_acc -= px;
         end else if (rsitts_pkg::RSI_SCALE * gains > cfg.overbought_level * total
                      && units > -lim) begin
            r.act = rsitts_pkg::ACT_SELL;
            units--;
            if (CASH_HI - cash_acc < px) cash_acc = CASH_HI;
            else cash_acc += px;
         end
      end
      r.hold = 11'(units);
      r.cash = 48'(cash_acc);
      r.pnl = '0;
      r.pnl_flag = closing;

      // square-off on the last price of a series
      if (closing) begin
         pnl = cash_acc + units * px;
         if (pnl > PNL_HI) pnl = PNL_HI;
         if (pnl < PNL_LO) pnl = PNL_LO;
         r.pnl = 49'(pnl);
         units = 0;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t ERROR %s: got %h, want %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Response checker
   always @(posedge clock) begin : check_responses
      trade_outcome_type want;
      logic [10:0]       got_hold;
      logic [47:0]       got_cash;
      logic [48:0]       got_pnl;
      got_hold = rsp_tdata[rsitts_pkg::HOLD_LSB +: rsitts_pkg::HOLD_W];
      got_cash = rsp_tdata[rsitts_pkg::CASH_LSB +: rsitts_pkg::CASH_W];
      got_pnl  = rsp_tdata[rsitts_pkg::PNL_LSB +: rsitts_pkg::PNL_W];
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("response with no request pending", 64'(rsp_tdata), 64'd0);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_tuser !== want.act)
               report_mismatch("action", 64'(rsp_tuser), 64'(want.act));
            if (got_hold !== want.hold)
               report_mismatch("holding", 64'(got_hold), 64'(want.hold));
            if (got_cash !== want.cash)
               report_mismatch("cash_total", 64'(got_cash), 64'(want.cash));
            if (got_pnl !== want.pnl)
               report_mismatch("closing pnl", 64'(got_pnl), 64'(want.pnl));
            if (rsp_tlast !== want.pnl_flag)
               report_mismatch("pnl_valid", 64'(rsp_tlast), 64'(want.pnl_flag));
         end
      end
   end

   // One price request; entered and left at a falling edge, tvalid left high
   task automatic send_tick(input logic [31:0] price, input logic trading,
                            input logic closing);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= price;
      req_tuser  <= trading;
      req_tlast  <= closing;
      do @(posedge clock); while (!req_tready);
      pending_outcomes.insert(pending_outcomes.size(),
                              predict_trade(price, trading, closing));
      @(negedge clock);
   endtask

   // Random-walk price with trending runs, so RSI reaches both extremes
   task automatic send_random_tick();
      logic [31:0] step;
      if ($urandom_range(19) == 0) trend_up = ~trend_up;
      step = $urandom >> $urandom_range(31, 6);
      case ($urandom_range(9))
         0: walk_price = $urandom;
         1: ;
         default: begin
            if (trend_up ^ ($urandom_range(3) == 0)) walk_price = walk_price + step;
            else walk_price = walk_price - step;
         end
      endcase
      send_tick(walk_price, $urandom_range(9) != 0, $urandom_range(39) == 0);
   endtask

   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      while (pending_outcomes.size() != 0) @(negedge clock);
   endtask

   // Register write: setup then access; psel lowered by the caller
   task automatic csr_write(input rsitts_pkg::reg_index_type idx,
                            input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         rsitts_pkg::REG_WINDOW_LEN:
            cfg.window_len       = value[rsitts_pkg::WLEN_W-1:0];
         rsitts_pkg::REG_POSITION_LIMIT:
            cfg.position_limit   = value[rsitts_pkg::LIMIT_W-1:0];
         rsitts_pkg::REG_OVERSOLD:
            cfg.oversold_level   = value[rsitts_pkg::LEVEL_W-1:0];
         rsitts_pkg::REG_OVERBOUGHT:
            cfg.overbought_level = value[rsitts_pkg::LEVEL_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Write all four registers once the block is idle; upper bits carry junk
   task automatic apply_settings(input int unsigned wlen, input int unsigned limit,
                                 input int unsigned low_lvl, input int unsigned high_lvl);
      wait_results_drained();
      csr_write(rsitts_pkg::REG_WINDOW_LEN,     ($urandom << rsitts_pkg::WLEN_W) | wlen);
      csr_write(rsitts_pkg::REG_POSITION_LIMIT, ($urandom << rsitts_pkg::LIMIT_W) | limit);
      csr_write(rsitts_pkg::REG_OVERSOLD,       ($urandom << rsitts_pkg::LEVEL_W) | low_lvl);
      csr_write(rsitts_pkg::REG_OVERBOUGHT,     ($urandom << rsitts_pkg::LEVEL_W) | high_lvl);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic randomize_settings();
      int unsigned wlen;
      int unsigned limit;
      wlen  = ($urandom_range(9) < 7) ? $urandom_range(1, 16) : $urandom_range(0, 127);
      limit = ($urandom_range(9) < 7) ? $urandom_range(0, 8) : $urandom_range(0, 1023);
      apply_settings(wlen, limit, $urandom_range(0, 60), $urandom_range(40, 127));
   endtask

   // Default registers: first price, flat window, trading off, sells to limit
   task automatic test_directed_basics();
      send_tick(32'd0, 1'b1, 1'b1);            // first price only, end still reports
      send_tick(32'd0, 1'b1, 1'b0);            // no gain and no loss
      send_tick(32'h8000_0000, 1'b0, 1'b0);    // rally while trading is off
      for (int i = 1; i <= 6; i++)             // gain-only window: RSI 100, sell to -5
         send_tick(32'h8000_0000 + i, 1'b1, 1'b0);
      send_tick(32'hFFFF_FFFF, 1'b1, 1'b1);    // short at limit, end reports PnL
      send_tick(32'd0, 1'b1, 1'b0);            // crash back to zero
   endtask

   // Window of one: buys on falls, sells on rises, position caps both ways
   task automatic test_position_limits();
      apply_settings(1, 1, 30, 70);
      send_tick(32'd5000, 1'b1, 1'b0);
      send_tick(32'd4000, 1'b1, 1'b0);         // long at limit
      send_tick(32'd6000, 1'b1, 1'b0);
      send_tick(32'd7000, 1'b1, 1'b0);
      send_tick(32'd8000, 1'b1, 1'b1);         // short at limit, end
      apply_settings(1, 0, 30, 70);
      send_tick(32'd1000, 1'b1, 1'b0);         // zero limit blocks both sides
      send_tick(32'd9000, 1'b1, 1'b0);
   endtask

   // Register extremes: window zero and above the ring, levels above full scale
   task automatic test_settings_extremes();
      int unsigned wl [5];
      int unsigned lm [5];
      int unsigned os [5];
      int unsigned ob [5];
      wl = '{0, 127, 64, 65, 1};
      lm = '{0, 1023, 1023, 512, 1023};
      os = '{0, 127, 100, 101, 50};
      ob = '{0, 127, 0, 101, 50};
      send_idle_pct = 0;
      recv_stall_pct = 0;
      for (int s = 0; s < 5; s++) begin
         apply_settings(wl[s], lm[s], os[s], ob[s]);
         repeat (20) send_random_tick();
      end
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (3) begin
         randomize_settings();
         repeat (120) send_random_tick();
      end
   endtask

   // Long output hold-off fills the pipeline, then a full pause on the input
   task automatic test_backpressure();
      apply_settings(4, 3, 40, 60);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_left = 300;
      repeat (60) send_random_tick();
      wait_results_drained();
      repeat (30) send_random_tick();
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      req_tlast   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_basics();
      test_position_limits();
      test_settings_extremes();
      test_random_traffic(0, 0);
      test_random_traffic(85, 0);
      test_random_traffic(0, 85);
      test_random_traffic(33, 33);
      test_backpressure();

      // drain, then watch a little longer for stray responses
      wait_results_drained();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
